### design/lzd_pkg.sv
// ----------------------------------------------------------------------------
// lzd_pkg: shared types and constants for the LZ bitstream depacker
// Holds the item structs, item kinds, parser phases, status codes, sequencer states and config indices.
// ----------------------------------------------------------------------------
package lzd_pkg;

    // History depth; the address is the low bits of the output count.
    localparam int WINDOW_BYTES = 8192;

    typedef enum logic [1:0] {
        K_FEED    = 2'd0,
        K_PULL    = 2'd1,
        K_EXHAUST = 2'd2,
        K_NOP     = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] in_byte;
    } t_in_item;

    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic       need_byte;
        logic       done_res;
        logic [2:0] error_code;
    } t_out_item;

    typedef enum logic [3:0] {
        PH_FIRST  = 4'd0,
        PH_FLAG   = 4'd1,
        PH_LIT    = 4'd2,
        PH_CODE   = 4'd3,
        PH_SHORT3 = 4'd4,
        PH_BYTE2  = 4'd5,
        PH_DFLAG  = 4'd6,
        PH_DHI    = 4'd7,
        PH_DSHORT = 4'd8,
        PH_DLO    = 4'd9,
        PH_UNARY  = 4'd10,
        PH_LBITS  = 4'd11,
        PH_COPY   = 4'd12
    } t_phase;

    typedef enum logic [2:0] {
        ST_RUN     = 3'd0,
        ST_BADLEN  = 3'd1,
        ST_FAR     = 3'd2,
        ST_SHORT   = 3'd3,
        ST_LIMIT   = 3'd4,
        ST_EARLY   = 3'd5,
        ST_DONE    = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_RD,
        S_RDWAIT,
        S_WR,
        S_OUT
    } t_seq;

    localparam logic [0:0] CFG_MAX = 1'b0;
    localparam logic [0:0] CFG_MIN = 1'b1;

endpackage

### design/lzd_ram.sv
// ----------------------------------------------------------------------------
// lzd_ram: single-port history RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module lzd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### design/lz_bitstream_depacker.sv
// ----------------------------------------------------------------------------
// lz_bitstream_depacker: streaming LZ77 bit/byte depacker
// Parses a packed stream one flag bit per cycle while buffered bits last and hands out decoded bytes.
// ----------------------------------------------------------------------------
// Usage: each input beat carries a kind and a packed byte. A feed beat gives
// the parser one packed byte; a pull beat takes one decoded byte; an
// exhausted beat reports end of input. Every input beat yields exactly one
// output beat with the decoded byte (if any), need_byte, done and a sticky
// error code. The parser walks the stream one step per cycle under a small
// sequencer. An exhausted beat goes straight to the output stage; a feed
// beat steps the parser through its flag bits (up to eight) until a step
// finds it waiting; a pull that hands out a literal first writes it to
// history, and a pull that copies from history reads, waits and writes on
// the single RAM port, then steps through the buffered flag bits.
// The input is not ready while a beat is being worked or while its result
// waits in the output register; a stalled receiver holds the block there.
// Configuration writes (index 0 maximum output, 1 minimum output) are taken
// at any time and should only be issued while the block is idle.
// Reset returns the parser to expect a raw first literal, clears the count
// and status, and restores the register defaults 49152 and 256.
// ----------------------------------------------------------------------------
module lz_bitstream_depacker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  lzd_pkg::t_in_item   i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output lzd_pkg::t_out_item  o_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [0:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import lzd_pkg::*;

    localparam int AW = $clog2(WINDOW_BYTES);

    t_seq        r_seq, n_seq;
    logic [7:0]  r_byte, n_byte;
    logic        r_have, n_have;
    logic [7:0]  r_bbuf, n_bbuf;
    logic [7:0]  r_bmask, n_bmask;
    t_phase      r_ph, n_ph;
    logic [15:0] r_cnt, n_cnt;
    logic [8:0]  r_crem, n_crem;
    logic [12:0] r_cdist, n_cdist;
    logic [11:0] r_acc, n_acc;
    logic [3:0]  r_lcls, n_lcls;
    logic [8:0]  r_pend, n_pend;
    t_status     r_st, n_st;
    logic [15:0] r_max, r_min;
    logic        r_ov, n_ov;
    logic [7:0]  r_ob, n_ob;
    t_out_item   r_out, n_out;
    logic        r_oval, n_oval;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wd, ram_rd;

    lzd_ram #(.WIDTH(8), .DEPTH(WINDOW_BYTES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wd),
        .o_rdata(ram_rd)
    );

    assign o_ready     = (r_seq == S_IDLE) && !r_oval;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_oval;
    assign o_data      = r_out;

    logic       pending;
    logic [7:0] m_sh;
    logic       bit_ok, bit_val;
    logic [7:0] nb_buf, nb_mask;
    logic       nb_used;
    logic [15:0] sc_dist;
    logic        sc_do;
    logic [8:0]  sc_len;
    logic [15:0] v_lo;

    assign pending = r_pend[8] || (r_ph == PH_COPY);

    // Fetch of the next flag bit, refilling from the held byte when empty.
    always_comb begin
        m_sh    = r_bmask >> 1;
        nb_buf  = r_bbuf;
        nb_mask = m_sh;
        nb_used = 1'b0;
        bit_ok  = 1'b1;
        if (m_sh == 8'd0) begin
            if (r_have) begin
                nb_buf  = r_byte;
                nb_mask = 8'h80;
                nb_used = 1'b1;
            end else begin
                bit_ok = 1'b0;
            end
        end
        bit_val = |(nb_buf & nb_mask);
    end

    always_comb begin
        v_lo = ((16'hf000 | {4'd0, r_acc[3:0], 8'd0}) - 16'h0100) | {8'd0, r_byte};
    end

    always_comb begin
        n_seq = r_seq; n_byte = r_byte; n_have = r_have;
        n_bbuf = r_bbuf; n_bmask = r_bmask; n_ph = r_ph; n_cnt = r_cnt;
        n_crem = r_crem; n_cdist = r_cdist; n_acc = r_acc; n_lcls = r_lcls;
        n_pend = r_pend; n_st = r_st; n_ov = r_ov; n_ob = r_ob;
        n_out = r_out; n_oval = r_oval;
        ram_we = 1'b0;
        ram_addr = r_cnt[AW-1:0] - r_cdist[AW-1:0];
        ram_wd = r_ob;
        sc_do = 1'b0; sc_dist = 16'd0; sc_len = 9'd0;

        if (r_oval && i_ready) begin
            n_oval = 1'b0;
        end

        case (r_seq)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_byte = i_data.in_byte;
                    n_ov = 1'b0;
                    n_ob = 8'd0;
                    n_have = 1'b0;
                    case (t_kind'(i_data.kind))
                        K_FEED: begin
                            n_have = 1'b1;
                            n_seq = S_STEP;
                        end
                        K_PULL: begin
                            if (r_pend[8]) begin
                                n_ob = r_pend[7:0];
                                n_ov = 1'b1;
                                n_pend = 9'd0;
                                n_seq = S_WR;
                            end else if (r_ph == PH_COPY) begin
                                if (r_cnt == 16'hffff) begin
                                    n_st = ST_LIMIT;
                                    n_crem = 9'd0;
                                    n_ph = PH_FLAG;
                                    n_seq = S_STEP;
                                end else begin
                                    n_seq = S_RD;
                                end
                            end else begin
                                n_seq = S_STEP;
                            end
                        end
                        K_EXHAUST: begin
                            if (r_st == ST_RUN && !pending) n_st = ST_EARLY;
                            n_seq = S_OUT;
                        end
                        default: n_seq = S_STEP;
                    endcase
                end
            end
            S_RD: begin
                n_seq = S_RDWAIT;
            end
            S_RDWAIT: begin
                n_ob = ram_rd;
                n_ov = 1'b1;
                n_crem = r_crem - 9'd1;
                if (r_crem == 9'd1) n_ph = PH_FLAG;
                n_seq = S_WR;
            end
            S_WR: begin
                ram_we = 1'b1;
                ram_addr = r_cnt[AW-1:0];
                n_cnt = r_cnt + 16'd1;
                n_seq = S_STEP;
            end
            S_STEP: begin
                if (r_st != ST_RUN || pending) begin
                    n_seq = S_OUT;
                end else begin
                    case (r_ph)
                        PH_FIRST, PH_LIT: begin
                            if (!r_have) n_seq = S_OUT;
                            else begin
                                n_have = 1'b0;
                                n_pend = {1'b1, r_byte};
                                n_ph = PH_FLAG;
                            end
                        end
                        PH_FLAG: begin
                            if (r_cnt >= r_max) begin
                                n_st = ST_LIMIT;
                            end else if (!bit_ok) begin
                                n_seq = S_OUT;
                            end else begin
                                n_bbuf = nb_buf; n_bmask = nb_mask;
                                if (nb_used) n_have = 1'b0;
                                n_acc = 12'd0;
                                n_lcls = 4'd2;
                                n_ph = bit_val ? PH_LIT : PH_CODE;
                            end
                        end
                        PH_CODE, PH_SHORT3, PH_DHI, PH_LBITS: begin
                            if (!bit_ok) n_seq = S_OUT;
                            else begin
                                n_bbuf = nb_buf; n_bmask = nb_mask;
                                if (nb_used) n_have = 1'b0;
                                n_acc = {r_acc[10:0], bit_val};
                                n_lcls = r_lcls - 4'd1;
                                if (r_lcls == 4'd1) begin
                                    case (r_ph)
                                        PH_SHORT3: begin
                                            sc_do = 1'b1;
                                            sc_dist = 16'd8 - {13'd0, n_acc[2:0]};
                                            sc_len = 9'd1;
                                        end
                                        PH_DHI: n_ph = PH_DLO;
                                        PH_LBITS: begin
                                            n_crem = r_crem + n_acc[8:0];
                                            n_ph = PH_DFLAG;
                                        end
                                        default: begin
                                            if (n_acc == 12'd0) begin
                                                n_lcls = 4'd3; n_ph = PH_SHORT3;
                                            end else if (n_acc == 12'd1) begin
                                                n_ph = PH_BYTE2;
                                            end else if (n_acc == 12'd2) begin
                                                n_crem = 9'd3; n_ph = PH_DFLAG;
                                            end else begin
                                                n_lcls = 4'd1; n_ph = PH_UNARY;
                                            end
                                        end
                                    endcase
                                end
                            end
                        end
                        PH_BYTE2, PH_DSHORT: begin
                            if (!r_have) n_seq = S_OUT;
                            else begin
                                n_have = 1'b0;
                                sc_do = 1'b1;
                                sc_dist = 16'd256 - {8'd0, r_byte};
                                sc_len = (r_ph == PH_BYTE2) ? 9'd2 : r_crem;
                            end
                        end
                        PH_DLO: begin
                            if (!r_have) n_seq = S_OUT;
                            else begin
                                n_have = 1'b0;
                                sc_do = 1'b1;
                                sc_dist = 16'd0 - v_lo;
                                sc_len = r_crem;
                            end
                        end
                        PH_DFLAG: begin
                            if (!bit_ok) n_seq = S_OUT;
                            else begin
                                n_bbuf = nb_buf; n_bmask = nb_mask;
                                if (nb_used) n_have = 1'b0;
                                if (bit_val) begin
                                    n_acc = 12'd0; n_lcls = 4'd4; n_ph = PH_DHI;
                                end else begin
                                    n_ph = PH_DSHORT;
                                end
                            end
                        end
                        PH_UNARY: begin
                            if (!bit_ok) n_seq = S_OUT;
                            else begin
                                n_bbuf = nb_buf; n_bmask = nb_mask;
                                if (nb_used) n_have = 1'b0;
                                if (bit_val) begin
                                    if (r_lcls == 4'd9) begin
                                        n_st = (r_cnt >= r_min) ? ST_DONE : ST_SHORT;
                                    end else if (r_lcls > 4'd7) begin
                                        n_st = ST_BADLEN;
                                    end else begin
                                        n_crem = 9'd2 + (9'd1 << r_lcls);
                                        n_acc = 12'd0;
                                        n_ph = PH_LBITS;
                                    end
                                end else begin
                                    n_lcls = r_lcls + 4'd1;
                                    if (r_lcls >= 4'd9) n_st = ST_BADLEN;
                                end
                            end
                        end
                        default: n_st = ST_BADLEN;
                    endcase
                    if (sc_do) begin
                        if (sc_dist > r_cnt) begin
                            n_st = ST_FAR;
                        end else begin
                            n_cdist = sc_dist[12:0];
                            n_crem = sc_len;
                            n_ph = PH_COPY;
                        end
                    end
                end
            end
            S_OUT: begin
                n_out.out_valid  = r_ov;
                n_out.out_byte   = r_ob;
                n_out.need_byte  = (r_st == ST_RUN) && !pending;
                n_out.done_res   = (r_st == ST_DONE);
                n_out.error_code = (r_st == ST_DONE) ? 3'd0 : r_st;
                n_oval = 1'b1;
                n_seq = S_IDLE;
            end
            default: n_seq = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= S_IDLE;
            r_have <= 1'b0;
            r_bbuf <= 8'd0;
            r_bmask <= 8'd0;
            r_ph <= PH_FIRST;
            r_cnt <= 16'd0;
            r_crem <= 9'd0;
            r_cdist <= 13'd0;
            r_acc <= 12'd0;
            r_lcls <= 4'd0;
            r_pend <= 9'd0;
            r_st <= ST_RUN;
            r_max <= 16'd49152;
            r_min <= 16'd256;
            r_oval <= 1'b0;
        end else begin
            r_seq <= n_seq;
            r_have <= n_have;
            r_bbuf <= n_bbuf;
            r_bmask <= n_bmask;
            r_ph <= n_ph;
            r_cnt <= n_cnt;
            r_crem <= n_crem;
            r_cdist <= n_cdist;
            r_acc <= n_acc;
            r_lcls <= n_lcls;
            r_pend <= n_pend;
            r_st <= n_st;
            r_oval <= n_oval;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_MAX) r_max <= i_cfg_data;
                else                        r_min <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_ov <= n_ov;
        r_ob <= n_ob;
        r_out <= n_out;
    end
endmodule
